>>> hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, character constants and helpers for the string escape encoder.
// ----------------------------------------------------------------------------
package sse_pkg;

    // Queue between the classifier and the serializer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Index of the final byte of an escape sequence.
    localparam logic [1:0] LAST_IDX_PLAIN = 2'd0;
    localparam logic [1:0] LAST_IDX_PAIR  = 2'd1;
    localparam logic [1:0] LAST_IDX_HEX   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic [31:0] escaped_length;
    } out_item_t;

    // One classified input byte: its escape sequence and how long it is.
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [1:0]      last_idx;
        logic            eos;
    } desc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] d;
        if (nibble < 4'd10)
        begin
            d = CH_ZERO + {4'd0, nibble};
        end
        else
        begin
            d = CH_LOWER_A + {4'd0, nibble} - 8'd10;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/sse_front.sv
// ----------------------------------------------------------------------------
// sse_front
// Holds the configuration register and turns each accepted input byte into
// an escape descriptor for the queue.
// ----------------------------------------------------------------------------
module sse_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  sse_pkg::in_item_t item,
    output sse_pkg::desc_t    desc
);
    import sse_pkg::*;

    logic keep_high_reg;
    logic is_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_high_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            keep_high_reg <= cfg_wr_data;
        end
    end

    assign is_ctrl = (item.in_byte < CH_SPACE) || (item.in_byte >= CH_DEL);

    always_comb
    begin
        desc.eos      = item.end_of_string;
        desc.seq      = '0;
        desc.seq[0]   = CH_BACKSLASH;
        desc.last_idx = LAST_IDX_PAIR;
        case (item.in_byte)
            CH_QUOTE:     desc.seq[1] = CH_QUOTE;
            CH_BACKSLASH: desc.seq[1] = CH_BACKSLASH;
            CH_TAB:       desc.seq[1] = CH_LOWER_T;
            CH_NEWLINE:   desc.seq[1] = CH_LOWER_N;
            CH_RETURN:    desc.seq[1] = CH_LOWER_R;
            default:
            begin
                if (!keep_high_reg && is_ctrl)
                begin
                    desc.seq[1]   = CH_LOWER_X;
                    desc.seq[2]   = hex_digit(item.in_byte[7:4]);
                    desc.seq[3]   = hex_digit(item.in_byte[3:0]);
                    desc.last_idx = LAST_IDX_HEX;
                end
                else
                begin
                    desc.seq[0]   = item.in_byte;
                    desc.last_idx = LAST_IDX_PLAIN;
                end
            end
        endcase
    end

endmodule

>>> hw/rtl/sse_queue.sv
// ----------------------------------------------------------------------------
// sse_queue
// Small register FIFO of escape descriptors between classifier and serializer.
// ----------------------------------------------------------------------------
module sse_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sse_pkg::desc_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sse_pkg::desc_t head
);
    import sse_pkg::*;

    desc_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/sse_back.sv
// ----------------------------------------------------------------------------
// sse_back
// Serializes the head descriptor into the output register one byte per cycle
// while out_ready allows, keeping the saturating escaped length per string.
// ----------------------------------------------------------------------------
module sse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sse_pkg::desc_t     q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sse_pkg::out_item_t out_data
);
    import sse_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic [31:0] count_reg, count_next;
    logic        valid_reg, valid_next;
    out_item_t   data_reg, data_next;
    logic        advance;
    logic        is_last;
    logic [31:0] count_inc;

    // A queued beat is loaded if the output register is empty or draining.
    assign advance   = q_valid && (!valid_reg || out_ready);
    assign is_last   = (idx_reg == q_head.last_idx);
    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 32'd1;
    assign q_pop     = advance && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        count_next = count_reg;
        data_next  = data_reg;
        valid_next = valid_reg && !out_ready;
        if (advance)
        begin
            valid_next               = 1'b1;
            data_next.out_byte       = q_head.seq[idx_reg];
            data_next.last_of_run    = is_last;
            data_next.escaped_length = count_inc;
            idx_next                 = is_last ? 2'd0 : idx_reg + 2'd1;
            count_next               = (is_last && q_head.eos) ? 32'd0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/string_escape_encoder.sv
// ----------------------------------------------------------------------------
// string_escape_encoder
// C-style string escaper with hex escapes for control and non-ASCII bytes unless keep_high_bytes is set.
// ----------------------------------------------------------------------------
// Each input beat is one raw byte and produces one, two or four output beats;
// the serializer emits one byte per cycle while out_ready allows, and that
// single output byte lane sets the throughput. Input beats are classified on
// acceptance and held in a four-entry queue, so the input keeps accepting
// while earlier bytes are still being serialized; an accepted byte passes the
// queue entry and then the output register. keep_high_bytes is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block does not enforce. escaped_length counts output bytes of
// the current string, saturates at its maximum and restarts when the string ends.
module string_escape_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  sse_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sse_pkg::out_item_t out_data
);
    import sse_pkg::*;

    desc_t front_desc;
    desc_t q_head;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    sse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (in_data),
        .desc        (front_desc)
    );

    sse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = !q_full;

endmodule
